// ===== rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lrpo_pkg.sv =====
// types and constants of the lru page replacement order
package lrpo_pkg;

  localparam int unsigned FRAMES  = 64;
  localparam int unsigned FRAME_W = $clog2(FRAMES);
  localparam int unsigned COUNT_W = $clog2(FRAMES + 1);

  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic {
    CMD_TOUCH = 1'b0,
    CMD_EVICT = 1'b1
  } cmd_e;

  typedef struct packed {
    logic   victim_valid;
    frame_t victim_frame;
    count_t resident_count;
  } result_t;

endpackage

// ===== rtl/lrpo_if.sv =====
// command and result channel interfaces
interface lrpo_cmd_if import lrpo_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   command;
  frame_t page_frame;

  modport source (output valid, output command, output page_frame, input ready);
  modport sink (input valid, input command, input page_frame, output ready);
endinterface

interface lrpo_res_if import lrpo_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   victim_valid;
  frame_t victim_frame;
  count_t resident_count;

  modport source (output valid, output victim_valid, output victim_frame,
                  output resident_count, input ready);
  modport sink (input valid, input victim_valid, input victim_frame,
                input resident_count, output ready);
endinterface

// ===== rtl/lrpo_ram.sv =====
// generic simple dual-port ram with registered read
module lrpo_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lrpo_result_reg.sv =====
// output register for result transfers
module lrpo_result_reg import lrpo_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  result_t           result_i,
  output logic              free_o,
  lrpo_res_if.source        res_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  assign free_o  = !valid_q || res_o.ready;
  assign valid_d = load_i || (valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign res_o.valid          = valid_q;
  assign res_o.victim_valid   = data_q.victim_valid;
  assign res_o.victim_frame   = data_q.victim_frame;
  assign res_o.resident_count = data_q.resident_count;

endmodule

// ===== rtl/lru_page_replacement_order.sv =====
// lru page replacement order, top level
// non-resident touch, evict on empty order: go straight from idle to finish, where the result is registered
// other items walk the order ram up to the resident count, then register the result in finish
// one item at a time: the next command transfer waits for the idle state after the result is registered
// a stalled result output holds the block until the result register frees up
// reset clears resident bits and count at once; the order ram is not cleared
`include "assert_macros.svh"

module lru_page_replacement_order import lrpo_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  lrpo_cmd_if.sink    cmd_i,
  lrpo_res_if.source  res_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_WALK   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  state_e              state_q, state_d;
  count_t              len_q, len_d;
  logic [FRAMES-1:0]   present_q, present_d;
  count_t              rd_idx_q, rd_idx_d;
  logic                pend_q, pend_d;
  logic                found_q, found_d;
  cmd_e                cmd_q, cmd_d;
  frame_t              frame_q, frame_d;
  frame_t              victim_q, victim_d;
  frame_t              pend_idx_q, pend_idx_d;

  logic    ram_we;
  frame_t  ram_waddr, ram_wdata, ram_raddr, ram_rdata;
  logic    res_free, res_load;
  result_t result;
  count_t  len_dec;
  logic    match;

  assign len_dec     = len_q - COUNT_W'(1);
  assign cmd_i.ready = (state_q == ST_IDLE);
  assign match       = (cmd_q == CMD_EVICT) ? (pend_idx_q == '0) : (ram_rdata == frame_q);

  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    present_d  = present_q;
    rd_idx_d   = rd_idx_q;
    pend_d     = pend_q;
    found_d    = found_q;
    cmd_d      = cmd_q;
    frame_d    = frame_q;
    victim_d   = victim_q;
    pend_idx_d = pend_idx_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_raddr  = rd_idx_q[FRAME_W-1:0];
    res_load   = 1'b0;
    result     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_i.valid) begin
          cmd_d    = cmd_e'(cmd_i.command);
          frame_d  = cmd_i.page_frame;
          rd_idx_d = '0;
          pend_d   = 1'b0;
          found_d  = 1'b0;
          victim_d = '0;
          if (cmd_e'(cmd_i.command) == CMD_TOUCH) begin
            state_d = present_q[cmd_i.page_frame] ? ST_WALK : ST_FINISH;
          end else begin
            state_d = (len_q != '0) ? ST_WALK : ST_FINISH;
          end
        end
      end
      ST_WALK: begin
        // reads run one entry ahead of the shift-down writes
        if (rd_idx_q != len_q) begin
          rd_idx_d   = rd_idx_q + COUNT_W'(1);
          pend_d     = 1'b1;
          pend_idx_d = rd_idx_q[FRAME_W-1:0];
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          if (found_q) begin
            ram_we    = 1'b1;
            ram_waddr = pend_idx_q - FRAME_W'(1);
            ram_wdata = ram_rdata;
          end
          if (match) begin
            found_d = 1'b1;
            if (cmd_q == CMD_EVICT) begin
              victim_d = ram_rdata;
            end
          end
          if (rd_idx_q == len_q) begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (res_free) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
          if (cmd_q == CMD_TOUCH) begin
            ram_we    = 1'b1;
            ram_wdata = frame_q;
            if (found_q) begin
              ram_waddr = len_dec[FRAME_W-1:0];
            end else begin
              ram_waddr         = len_q[FRAME_W-1:0];
              len_d             = len_q + COUNT_W'(1);
              present_d[frame_q] = 1'b1;
            end
            result.resident_count = len_d;
          end else begin
            if (found_q) begin
              len_d               = len_dec;
              present_d[victim_q] = 1'b0;
              result.victim_valid = 1'b1;
              result.victim_frame = victim_q;
            end
            result.resident_count = len_d;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      len_q     <= '0;
      present_q <= '0;
      rd_idx_q  <= '0;
      pend_q    <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      present_q <= present_d;
      rd_idx_q  <= rd_idx_d;
      pend_q    <= pend_d;
      found_q   <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    frame_q    <= frame_d;
    victim_q   <= victim_d;
    pend_idx_q <= pend_idx_d;
  end

  lrpo_ram #(
    .WIDTH(FRAME_W),
    .DEPTH(FRAMES)
  ) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lrpo_result_reg u_result_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (res_load),
    .result_i (result),
    .free_o   (res_free),
    .res_o    (res_o)
  );

  `ASSERT_ALWAYS(a_count_matches_present, $countones(present_q) == int'(len_q), "count mismatch")
  `ASSERT_ALWAYS(a_count_in_range, len_q <= COUNT_W'(FRAMES), "count overflow")
  `ASSERT_IMPLY(a_walk_idx_in_range, state_q == ST_WALK, rd_idx_q <= len_q, "walk overrun")
  `ASSERT_IMPLY(a_append_absent, state_q == ST_FINISH && cmd_q == CMD_TOUCH && !found_q,
                !present_q[frame_q], "append of resident frame")

endmodule
